### hw/rtl/svhd_pkg.sv
// Shared types, widths and codes for the stereo vibrato delay.
package svhd_pkg;

  localparam int LINE_MAX_DEF  = 256;
  localparam int PHASE_MAX_DEF = 16384;

  localparam int SAMPLE_W  = 16;
  localparam int LEN_REG_W = 9;
  localparam int PER_REG_W = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;
  localparam int TIDX_W    = 14;
  localparam int DELAY_W   = 25;
  localparam int FRAC_W    = 16;
  // whole-sample part of a delay plus the borrow and the one-sample offset
  localparam int QUOT_W    = DELAY_W - FRAC_W + 1;

  // Hermite datapath
  localparam int COEF_W = 20;
  localparam int ACC_W  = 38;
  localparam int MAG_W  = ACC_W - 1;
  localparam int LO_W   = 18;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = MAG_W + FRAC_W;

  localparam int LEN_MIN    = 4;
  localparam int SAMPLE_MAX = 32767;

  localparam logic [LEN_REG_W-1:0] LEN_RESET = 9'd176;
  localparam logic [PER_REG_W-1:0] PER_RESET = 15'd8820;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_PERIOD  = 1'd1;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic [TIDX_W-1:0]          table_index;
    logic [DELAY_W-1:0]         table_value;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } res_beat_t;

  typedef struct packed {
    logic              start;
    logic [FRAC_W-1:0] frac;
  } lane_cmd_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
  } lane_stat_t;

endpackage

### hw/rtl/stereo_vibrato_hermite_delay.sv
// Top level of the stereo vibrato delay with Hermite interpolation.
//
// Command channel (cmd_valid / cmd_stall / cmd_beat): a CMD_FRAME beat carries
//   one left and one right sample and yields one result beat; a CMD_TABLE beat
//   writes one Q16 delay-table entry and yields nothing (indexes at or beyond
//   PHASE_MAX are dropped).
// Result channel (res_valid / res_stall / res_beat): one stereo frame per frame
//   beat, in order, from an output register that holds while res_stall is high;
//   the next frame is taken in meanwhile.
// Config port (cfg_we / cfg_index / cfg_data): line_length, lfo_period; write
//   only while no frame is in flight.
// Sequence: a frame beat passes the table read, the 10-step serial remainder
//   unit and each lane's 4-tap line fetch plus three Horner steps of two
//   passes through one 19x16 multiplier; cmd_stall stays high until the frame
//   reaches res_valid, so a new frame is taken only once the last is through.
//   A table beat leaves the block ready for the next beat. A finished frame
//   that finds the output register stalled waits in the last state until free.
// Reset: both delay lines are cleared by a sweep over all LINE_MAX entries;
//   cmd_stall stays high during the sweep, config writes are still taken. The
//   delay table is not cleared and must be written before use.
module stereo_vibrato_hermite_delay import svhd_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int PHASE_MAX = PHASE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_beat_t            cmd_beat,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_beat_t            res_beat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(LINE_MAX);
  localparam int LW     = AW + 1;
  localparam int PW     = $clog2(PHASE_MAX);
  localparam int PERW   = $clog2(PHASE_MAX + 1);
  localparam int LC_W   = ((LEN_REG_W > LW) ? LEN_REG_W : LW) + 1;
  localparam int PC_W   = ((PER_REG_W > PERW) ? PER_REG_W : PERW) + 1;
  localparam int IDXC_W = ((TIDX_W > PW) ? TIDX_W : PW) + 1;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TBL   = 3'd2;
  localparam logic [2:0] S_QLOAD = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_LANE  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [AW-1:0]  clr_cnt;
  logic           clearing;

  // config and running state
  logic [LEN_REG_W-1:0] line_length;
  logic [PER_REG_W-1:0] lfo_period;
  logic [AW-1:0]        wp;
  logic [PW-1:0]        ph;

  // per-frame snapshot
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic [LW-1:0]              len_r;
  logic [PERW-1:0]            per_r;
  logic [AW-1:0]              w_r;
  logic [FRAC_W-1:0]          x_r;

  logic cmd_acc;
  logic frame_acc;
  logic tbl_we;
  logic fin_go;

  assign clearing  = (state == S_CLEAR);
  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign frame_acc = cmd_acc && (cmd_beat.command == CMD_FRAME);
  assign fin_go    = (state == S_FIN) && (!res_valid || !res_stall);

  // clamp registers into their legal ranges
  logic [LC_W-1:0] len_ext;
  logic [LW-1:0]   len_eff;
  logic [PC_W-1:0] per_ext;
  logic [PERW-1:0] per_eff;

  assign len_ext = LC_W'(line_length);
  assign per_ext = PC_W'(lfo_period);

  always_comb begin
    if (len_ext < LC_W'(LEN_MIN)) begin
      len_eff = LW'(LEN_MIN);
    end else if (len_ext > LC_W'(LINE_MAX)) begin
      len_eff = LW'(LINE_MAX);
    end else begin
      len_eff = LW'(line_length);
    end
    if (per_ext == '0) begin
      per_eff = PERW'(1);
    end else if (per_ext > PC_W'(PHASE_MAX)) begin
      per_eff = PERW'(PHASE_MAX);
    end else begin
      per_eff = PERW'(lfo_period);
    end
  end

  // delay table: written by table beats, read at the LFO phase
  logic [DELAY_W-1:0] tbl_rd;

  assign tbl_we = cmd_acc && (cmd_beat.command == CMD_TABLE)
                  && (IDXC_W'(cmd_beat.table_index) < IDXC_W'(PHASE_MAX));

  svhd_ram #(.WIDTH(DELAY_W), .DEPTH(PHASE_MAX)) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (PW'(cmd_beat.table_index)),
    .wr_data (cmd_beat.table_value),
    .rd_addr (ph),
    .rd_data (tbl_rd)
  );

  // read point = w - 1 - delay; split into whole samples and fraction.
  // A nonzero fraction borrows one more sample.
  logic [FRAC_W-1:0]          dfrac;
  logic [DELAY_W-FRAC_W-1:0]  dwhole;
  logic [QUOT_W-1:0]          back;
  logic [FRAC_W-1:0]          frac;

  assign dfrac  = tbl_rd[FRAC_W-1:0];
  assign dwhole = tbl_rd[DELAY_W-1:FRAC_W];
  assign back   = QUOT_W'(dwhole) + QUOT_W'(1) + QUOT_W'(|dfrac);
  assign frac   = ~dfrac + FRAC_W'(1);

  logic          mod_done;
  logic [LW-1:0] mod_rem;

  svhd_mod #(.LEN_W(LW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_QLOAD),
    .dividend (back),
    .divisor  (len_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // base tap = (w - back) mod len, one correction since both are below len
  logic [LW-1:0] w_ext;
  logic [LW-1:0] base_w;

  assign w_ext  = LW'(w_r);
  assign base_w = (w_ext >= mod_rem) ? w_ext - mod_rem : w_ext + len_r - mod_rem;

  // lanes: both channels run in lockstep off one command
  lane_cmd_t  lane_cmd;
  lane_stat_t left_stat;
  lane_stat_t right_stat;
  logic          line_we;
  logic [AW-1:0] line_addr;

  assign lane_cmd.start = (state == S_MOD) && mod_done;
  assign lane_cmd.frac  = x_r;
  assign line_we        = clearing || fin_go;
  assign line_addr      = clearing ? clr_cnt : w_r;

  svhd_lane #(.LINE_MAX(LINE_MAX)) u_left (
    .clk     (clk),
    .rst     (rst),
    .cmd     (lane_cmd),
    .base    (base_w[AW-1:0]),
    .len     (len_r),
    .wr_en   (line_we),
    .wr_addr (line_addr),
    .wr_data (clearing ? '0 : left_r),
    .stat    (left_stat)
  );

  svhd_lane #(.LINE_MAX(LINE_MAX)) u_right (
    .clk     (clk),
    .rst     (rst),
    .cmd     (lane_cmd),
    .base    (base_w[AW-1:0]),
    .len     (len_r),
    .wr_en   (line_we),
    .wr_addr (line_addr),
    .wr_data (clearing ? '0 : right_r),
    .stat    (right_stat)
  );

  // write position and phase advance
  logic [LW-1:0]   w_inc;
  logic [AW-1:0]   wp_next;
  logic [PERW-1:0] ph_inc;
  logic [PW-1:0]   ph_next;

  assign w_inc   = LW'(w_r) + LW'(1);
  assign wp_next = (w_inc >= len_r) ? '0 : w_inc[AW-1:0];
  assign ph_inc  = PERW'(ph) + PERW'(1);
  assign ph_next = (ph_inc >= per_r) ? '0 : ph_inc[PW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == AW'(LINE_MAX - 1)) state_next = S_IDLE;
      S_IDLE:  if (frame_acc) state_next = S_TBL;
      S_TBL:   state_next = S_QLOAD;
      S_QLOAD: state_next = S_MOD;
      S_MOD:   if (mod_done) state_next = S_LANE;
      S_LANE:  if (left_stat.done) state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      wp          <= '0;
      ph          <= '0;
      res_valid   <= 1'b0;
      line_length <= LEN_RESET;
      lfo_period  <= PER_RESET;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LINE_LENGTH: line_length <= cfg_data[LEN_REG_W-1:0];
          REG_LFO_PERIOD:  lfo_period  <= cfg_data[PER_REG_W-1:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        wp        <= wp_next;
        ph        <= ph_next;
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (frame_acc) begin
      left_r  <= cmd_beat.left_in;
      right_r <= cmd_beat.right_in;
      len_r   <= len_eff;
      per_r   <= per_eff;
      w_r     <= (LW'(wp) >= len_eff) ? '0 : wp;
    end
    if (state == S_QLOAD) begin
      x_r <= frac;
    end
    // merge: both lane results into one output beat
    if (fin_go) begin
      res_beat.left_out  <= left_stat.sample;
      res_beat.right_out <= right_stat.sample;
    end
  end

`ifndef ASSERT_OFF
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    left_stat.done == right_stat.done)
    else $error("lanes finished in different cycles");

  a_wp_in_line: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> LW'(wp) < $past(len_r))
    else $error("write position beyond line length");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(fin_go))
    else $error("result valid without a finished frame");
`endif

endmodule

### hw/rtl/svhd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module svhd_ram import svhd_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = LINE_MAX_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/svhd_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module svhd_mod import svhd_pkg::*; #(
  parameter int LEN_W = LEN_REG_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [LEN_W-1:0]  rem
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [QUOT_W-1:0] shreg;
  logic [LEN_W-1:0]  div_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    trial_sub;

  assign trial     = {rem_r, shreg[QUOT_W-1]};
  assign trial_sub = (trial >= {1'b0, div_r}) ? trial - {1'b0, div_r} : trial;
  assign rem       = rem_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem_r <= trial_sub[LEN_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem_r < div_r)
    else $error("remainder not below divisor");
`endif

endmodule

### hw/rtl/svhd_lane.sv
// One channel: delay line, 4-tap fetch and Q16 Hermite Horner engine.
module svhd_lane import svhd_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int AW = $clog2(LINE_MAX),
  localparam int LW = AW + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_cmd_t                  cmd,
  input  logic [AW-1:0]              base,
  input  logic [LW-1:0]              len,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  output lane_stat_t                 stat
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_RD   = 3'd1;
  localparam logic [2:0] L_COEF = 3'd2;
  localparam logic [2:0] L_MHI  = 3'd3;
  localparam logic [2:0] L_MLO  = 3'd4;
  localparam logic [2:0] L_ACC  = 3'd5;
  localparam logic [2:0] L_FIN  = 3'd6;

  localparam int FQ_W   = MAG_W - FRAC_W;
  localparam int MULP_W = HI_W + FRAC_W;
  localparam logic [PROD_W-1:0] PROD_HALF =
    {{(PROD_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};
  localparam logic [MAG_W:0] FIN_HALF =
    {{(MAG_W - FRAC_W){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  logic [2:0]                 state;
  logic [2:0]                 cnt;
  logic [1:0]                 step;
  logic [AW-1:0]              base_r;
  logic [LW-1:0]              len_r;
  logic [FRAC_W-1:0]          x_r;
  logic signed [SAMPLE_W-1:0] y [4];
  logic signed [COEF_W-1:0]   coef [3];
  logic signed [ACC_W-1:0]    acc;
  logic [MULP_W-1:0]          p_hi;
  logic [LO_W+FRAC_W-1:0]     p_lo;
  logic                       done;
  logic signed [SAMPLE_W-1:0] sample;

  // tap address, wrapped once past the line end
  logic [LW-1:0]   tap_sum;
  logic [LW-1:0]   tap_wrap;
  logic [AW-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [1:0]      cap_idx;

  assign tap_sum  = LW'(base_r) + LW'(cnt[1:0]);
  assign tap_wrap = (tap_sum >= len_r) ? tap_sum - len_r : tap_sum;
  assign rd_addr  = tap_wrap[AW-1:0];
  assign cap_idx  = 2'(cnt - 3'd1);

  svhd_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_MAX)) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // coefficients, 3/4/5 factors as shift-adds
  logic signed [COEF_W-1:0] e0, e1, e2, e3, d12;
  logic signed [COEF_W-1:0] c0, c1, c2, c3;

  assign e0  = COEF_W'(y[0]);
  assign e1  = COEF_W'(y[1]);
  assign e2  = COEF_W'(y[2]);
  assign e3  = COEF_W'(y[3]);
  assign d12 = e1 - e2;
  assign c0  = e1 <<< 1;
  assign c1  = e2 - e0;
  assign c2  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign c3  = e3 - e0 + d12 + (d12 <<< 1);

  // sign-magnitude Horner step
  logic                     acc_neg;
  logic [ACC_W-1:0]         acc_abs;
  logic [MAG_W-1:0]         mag;
  logic [HI_W-1:0]          mul_a;
  logic [MULP_W-1:0]        mul_p;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod_rnd;
  logic [ACC_W-1:0]         rext;
  logic signed [ACC_W-1:0]  term;
  logic signed [COEF_W-1:0] coef_sel;

  assign acc_neg  = acc[ACC_W-1];
  assign acc_abs  = acc_neg ? -acc : acc;
  assign mag      = acc_abs[MAG_W-1:0];
  assign mul_a    = (state == L_MHI) ? mag[MAG_W-1:LO_W] : HI_W'(mag[LO_W-1:0]);
  assign mul_p    = MULP_W'(mul_a) * MULP_W'(x_r);
  assign prod     = (PROD_W'(p_hi) << LO_W) + PROD_W'(p_lo);
  assign prod_rnd = prod + PROD_HALF;
  assign rext     = {1'b0, prod_rnd[PROD_W-1:FRAC_W]};
  assign term     = acc_neg ? -rext : rext;
  assign coef_sel = coef[step];

  // final halve, round, saturate
  logic [MAG_W:0]    fsum;
  logic [FQ_W-1:0]   fq;
  logic [FQ_W-1:0]   fq_neg;
  logic signed [SAMPLE_W-1:0] fin_sample;

  assign fsum   = {1'b0, mag} + FIN_HALF;
  assign fq     = fsum[MAG_W:FRAC_W+1];
  assign fq_neg = -fq;

  always_comb begin
    if (!acc_neg && fq > FQ_W'(SAMPLE_MAX)) begin
      fin_sample = SAMPLE_W'(SAMPLE_MAX);
    end else if (acc_neg && fq > FQ_W'(SAMPLE_MAX + 1)) begin
      fin_sample = SAMPLE_W'(-SAMPLE_MAX - 1);
    end else if (acc_neg) begin
      fin_sample = fq_neg[SAMPLE_W-1:0];
    end else begin
      fin_sample = fq[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            cnt   <= '0;
            state <= L_RD;
          end
        end
        L_RD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= L_COEF;
          end
        end
        L_COEF: begin
          step  <= '0;
          state <= L_MHI;
        end
        L_MHI: state <= L_MLO;
        L_MLO: state <= L_ACC;
        L_ACC: begin
          if (step == 2'd2) begin
            state <= L_FIN;
          end else begin
            step  <= step + 2'd1;
            state <= L_MHI;
          end
        end
        L_FIN: begin
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == L_IDLE && cmd.start) begin
      base_r <= base;
      len_r  <= len;
      x_r    <= cmd.frac;
    end
    if (state == L_RD && cnt != 3'd0) begin
      y[cap_idx] <= rd_data;
    end
    if (state == L_COEF) begin
      coef[0] <= c2;
      coef[1] <= c1;
      coef[2] <= c0;
      acc     <= ACC_W'(c3) <<< FRAC_W;
    end
    if (state == L_MHI) begin
      p_hi <= mul_p;
    end
    if (state == L_MLO) begin
      p_lo <= mul_p[LO_W+FRAC_W-1:0];
    end
    if (state == L_ACC) begin
      acc <= term + (ACC_W'(coef_sel) <<< FRAC_W);
    end
    if (state == L_FIN) begin
      sample <= fin_sample;
    end
  end

  assign stat.done   = done;
  assign stat.sample = sample;

`ifndef ASSERT_OFF
  a_tap_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == L_RD && cnt != 3'd4) |-> LW'(rd_addr) < len_r)
    else $error("tap address beyond line length");
`endif

endmodule

### test/stereo_vibrato_hermite_delay_tb.sv
// Self-checking testbench for the stereo vibrato delay: directed and random beats against a predictor.
module stereo_vibrato_hermite_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svhd_pkg::*;

  localparam int LINES          = LINE_MAX_DEF;
  localparam int PHASES         = PHASE_MAX_DEF;
  localparam longint Q16_ONE    = 65536;
  localparam int HOLDOFF_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES   = 40;    // margin after the last frame, covers a last table beat
  localparam int MAX_REPORTS    = 10;
  localparam int LIMIT_NS       = 4_000_000;

  // DUT ports; every input starts at a known value
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_beat_t cmd_beat  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res_beat;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_LENGTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Predictor state: its own copy of both lines, position, phase, table and registers
  logic signed [SAMPLE_W-1:0] left_line  [LINES] = '{default: '0};
  logic signed [SAMPLE_W-1:0] right_line [LINES] = '{default: '0};
  logic [DELAY_W-1:0]         delay_tbl  [PHASES];
  bit                         delay_set  [PHASES];  // entry written at least once
  int                         wr_pos        = 0;
  int                         lfo_phase_now = 0;
  logic [LEN_REG_W-1:0]       len_reg = LEN_RESET;
  logic [PER_REG_W-1:0]       per_reg = PER_RESET;

  res_beat_t due_frames [$];   // expected output frames, oldest first
  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_left  = 0;       // set at a rising edge, counted down by the receiver

  stereo_vibrato_hermite_delay dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_beat  (cmd_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_len();
    if (len_reg < LEN_MIN) return LEN_MIN;
    if (len_reg > LINES) return LINES;
    return len_reg;
  endfunction

  function automatic int eff_period();
    if (per_reg < 1) return 1;
    if (per_reg > PHASES) return PHASES;
    return per_reg;
  endfunction

  // Shift right with round half away from zero
  function automatic longint round_away(longint v, int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -mag : mag;
  endfunction

  // 4-point Hermite at Q16 fraction x, Horner form; result halved and saturated
  function automatic logic signed [SAMPLE_W-1:0] hermite_point(longint x, longint y0,
      longint y1, longint y2, longint y3);
    longint c0, c1, c2, c3, acc;
    c0  = 2 * y1;
    c1  = y2 - y0;
    c2  = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c3  = (y3 - y0) + 3 * (y1 - y2);
    acc = c3 * Q16_ONE;
    acc = round_away(acc * x, FRAC_W) + c2 * Q16_ONE;
    acc = round_away(acc * x, FRAC_W) + c1 * Q16_ONE;
    acc = round_away(acc * x, FRAC_W) + c0 * Q16_ONE;
    acc = round_away(acc, FRAC_W + 1);
    if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
    else if (acc < -SAMPLE_MAX - 1) acc = -SAMPLE_MAX - 1;
    return SAMPLE_W'(acc);
  endfunction

  // Update the predicted state with one accepted command beat; a frame beat
  // queues the frame the block must return.
  function automatic void advance_vibrato(cmd_beat_t b);
    int len, per, w, ph, base;
    longint m, r, x;
    res_beat_t f;
    if (b.command == CMD_TABLE) begin
      delay_tbl[b.table_index] = b.table_value;
      delay_set[b.table_index] = 1'b1;
      return;
    end
    len = eff_len();
    per = eff_period();
    w   = (wr_pos >= len) ? 0 : wr_pos;   // stale position after a shorter length
    ph  = lfo_phase_now;
    // read position = write position - 1 - delay, reduced fully mod the length
    m = longint'(len) * Q16_ONE;
    r = longint'(w) * Q16_ONE - Q16_ONE - longint'(delay_tbl[ph]);
    r = r % m;
    if (r < 0) r += m;
    base = int'(r >> FRAC_W);
    x    = r & (Q16_ONE - 1);
    f.left_out  = hermite_point(x, left_line[base % len], left_line[(base + 1) % len],
                                left_line[(base + 2) % len], left_line[(base + 3) % len]);
    f.right_out = hermite_point(x, right_line[base % len], right_line[(base + 1) % len],
                                right_line[(base + 2) % len], right_line[(base + 3) % len]);
    left_line[w]  = b.left_in;
    right_line[w] = b.right_in;
    wr_pos        = (w + 1 >= len) ? 0 : w + 1;
    lfo_phase_now = (ph + 1 >= per) ? 0 : ph + 1;   // also clears a stale phase
    due_frames.push_back(f);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Result beats are taken at a rising edge with valid high and stall low
  always @(posedge clk) begin : check_frames
    res_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_frames.size() == 0) begin
        flag_error($sformatf("frame with none expected: L=%0d R=%0d",
                             res_beat.left_out, res_beat.right_out));
      end else begin
        want = due_frames.pop_front();
        if (res_beat.left_out !== want.left_out)
          flag_error($sformatf("left_out expected %0d got %0d",
                               want.left_out, res_beat.left_out));
        if (res_beat.right_out !== want.right_out)
          flag_error($sformatf("right_out expected %0d got %0d",
                               want.right_out, res_beat.right_out));
      end
    end
  end

  // Receiver: random stall, or a counted hold-off when one is pending
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      res_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  // All fields random; unused fields of a beat carry noise
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b.command     = 1'($urandom);
    b.left_in     = SAMPLE_W'($urandom);
    b.right_in    = SAMPLE_W'($urandom);
    b.table_index = TIDX_W'($urandom);
    b.table_value = DELAY_W'($urandom);
    return b;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return SAMPLE_MAX;
    if (sel < 30) return -SAMPLE_MAX - 1;
    if (sel < 45) return SAMPLE_W'(int'($urandom_range(200)) - 100);
    return SAMPLE_W'($urandom);
  endfunction

  // Mostly in-contract delays (below twice the length), some beyond it
  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned sel, span;
    sel  = $urandom_range(99);
    span = 2 * eff_len() * Q16_ONE;
    if (sel < 5)  return '0;
    if (sel < 10) return '1;
    if (sel < 20) return DELAY_W'($urandom);
    if (sel < 30) return DELAY_W'($urandom_range(2 * eff_len() - 1) << FRAC_W);
    return DELAY_W'($urandom_range(span - 1));
  endfunction

  // Entered at a falling edge; leaves valid high at the next falling edge,
  // so the caller either sends again or drops valid in that step.
  task automatic send_beat(cmd_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      cmd_beat  <= random_beat();
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat  <= b;
    do @(posedge clk); while (cmd_stall);
    advance_vibrato(b);
    @(negedge clk);
  endtask

  task automatic send_table(int idx, logic [DELAY_W-1:0] val);
    cmd_beat_t b;
    b = random_beat();
    b.command     = CMD_TABLE;
    b.table_index = idx[TIDX_W-1:0];
    b.table_value = val;
    send_beat(b);
  endtask

  // A frame never reads an unwritten table entry: fill the current phase first
  task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    cmd_beat_t b;
    if (!delay_set[lfo_phase_now]) send_table(lfo_phase_now, pick_delay());
    b = random_beat();
    b.command  = CMD_FRAME;
    b.left_in  = l;
    b.right_in = r;
    send_beat(b);
  endtask

  // Drop valid, wait for every frame, then out the latency of a last table beat
  task automatic drain();
    cmd_valid <= 1'b0;
    while (due_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_LINE_LENGTH) len_reg = data[LEN_REG_W-1:0];
    else if (idx == REG_LFO_PERIOD) per_reg = data[PER_REG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only with the block idle; the length word carries
  // random upper bits, which the 9-bit register drops
  task automatic set_config(int len_val, int per_val);
    logic [CFG_W-1:0] len_word;
    drain();
    len_word = CFG_W'($urandom);
    len_word[LEN_REG_W-1:0] = len_val[LEN_REG_W-1:0];
    write_reg(REG_LINE_LENGTH, len_word);
    write_reg(REG_LFO_PERIOD, per_val[CFG_W-1:0]);
  endtask

  // ---------------------------------------------------------------- tests

  // Extremes at reset settings, then a 4-sample line where the write position
  // goes stale, taps wrap past the line end and a maximal delay is reduced.
  task automatic test_directed_edges();
    send_table(0, '0);
    send_frame(SAMPLE_MAX, -SAMPLE_MAX - 1);
    send_table(1, '1);
    send_frame(-SAMPLE_MAX - 1, SAMPLE_MAX);
    send_table(2, DELAY_W'(Q16_ONE - 1));
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_table(3, DELAY_W'(Q16_ONE / 2));
    send_frame(-SAMPLE_MAX - 1, -SAMPLE_MAX - 1);
    set_config(LEN_MIN, 8);                          // write position 4 is now stale
    send_table(4, DELAY_W'(3 * Q16_ONE / 2));        // half-sample fraction
    send_table(5, DELAY_W'(2 * LEN_MIN * Q16_ONE - 1));  // just under twice the length
    send_table(6, DELAY_W'(3 * Q16_ONE));
    send_table(7, DELAY_W'(2 * Q16_ONE));
    send_table(PHASES - 1, '1);                      // top table index
    // alternating full-scale swings push the interpolant into saturation
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_frame(SAMPLE_MAX, -SAMPLE_MAX - 1);
      else send_frame(-SAMPLE_MAX - 1, SAMPLE_MAX);
    end
  endtask

  // Register extremes, in and out of range; the order makes a long period
  // fall to 1 with the phase beyond it, and a long line shrink to 4.
  task automatic test_register_extremes();
    int len_list [8] = '{LINES, LEN_MIN, 0, 511, 3, LINES + 1, LINES, LEN_MIN};
    int per_list [8] = '{PHASES, 1, 0, 32767, PHASES + 1, 2, 1, PHASES};
    for (int k = 0; k < 8; k++) begin
      set_config(len_list[k], per_list[k]);
      repeat (20) send_frame(pick_sample(), pick_sample());
    end
  endtask

  // Random frames and table beats, new random settings every hundred beats
  task automatic test_random_stream(int n_items);
    int len_val, per_val;
    int unsigned sel;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        sel     = $urandom_range(99);
        len_val = (sel < 10) ? $urandom_range(511) : $urandom_range(LINES, LEN_MIN);
        sel     = $urandom_range(99);
        if (sel < 70) per_val = $urandom_range(64, 1);
        else if (sel < 90) per_val = $urandom_range(PHASES, 1);
        else per_val = $urandom_range(32767);
        set_config(len_val, per_val);
      end
      sel = $urandom_range(99);
      if (sel < 8) send_table($urandom_range(eff_period() - 1), pick_delay());
      else if (sel < 15) send_table($urandom_range(PHASES - 1), pick_delay());
      else send_frame(pick_sample(), pick_sample());
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming: the
  // output register and the finished frame behind it fill, so cmd_stall rises.
  task automatic test_output_holdoff();
    drain();
    @(posedge clk);
    holdoff_left = HOLDOFF_CYCLES;
    @(negedge clk);
    repeat (24) send_frame(pick_sample(), pick_sample());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 56;
    test_directed_edges();
    test_register_extremes();
    test_random_stream(480);

    send_idle_pct = 56;
    recv_idle_pct = 26;
    test_random_stream(480);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(480);
    test_output_holdoff();

    drain();
    if (due_frames.size() != 0)
      flag_error($sformatf("%0d frames never arrived", due_frames.size()));
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### stereo_vibrato_hermite_delay.f
hw/rtl/svhd_pkg.sv
hw/rtl/svhd_ram.sv
hw/rtl/svhd_mod.sv
hw/rtl/svhd_lane.sv
hw/rtl/stereo_vibrato_hermite_delay.sv
test/stereo_vibrato_hermite_delay_tb.sv
